FILE: src/metaball_field_shader_core_defines.svh
// Assertion macros used by the checker file.
`ifndef METABALL_FIELD_SHADER_CORE_DEFINES_SVH
`define METABALL_FIELD_SHADER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mfs_pkg.sv
// Shared types and constants of the metaball field shader.
`timescale 1ns / 1ps
package mfs_pkg;
  localparam int IDX_W     = 3;
  localparam int TAB_IDX_W = 5;
  localparam int COORD_W   = 12;
  localparam int RAD_W     = 8;
  localparam int PIX_W     = 9;
  localparam int DX_W      = 13;
  localparam int SQ_W      = 2 * DX_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int RR_W      = 2 * RAD_W;
  localparam int BLUE_W    = 8;
  localparam logic [BLUE_W-1:0] BLUE_MAX = 8'd255;

  localparam logic REQ_BALL  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } mfs_state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic hit;
  } mfs_tag_t;
endpackage

FILE: src/metaball_field_shader_core.sv
// Top level of the metaball field shader core.
//
//  channel  dir  request
//  s_axis   in   ball write (tuser 0) or pixel query (tuser 1)
//  m_axis   out  field sum and blue level, one per pixel query
//
// A pixel query blocks further requests while the sequencer sends one ball
// term a cycle into the divider, pausing while m_axis is stalled.
// The delay from pixel acceptance to result is set by the scan length and
// the divider depth.
// rst clears control and valid bits; the ball table is unknown until written.
// A stall on m_axis freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
module metaball_field_shader_core
  import mfs_pkg::*;
#(
  parameter int BALLS     = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ball_index, ball_x, ball_y, ball_radius, pixel_x, pixel_y, zero pad
  input  logic [55:0] s_axis_tdata,
  // req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // field_value, blue_level, zero pad
  output logic [((FRAC_BITS+1+BLUE_W+7)/8)*8-1:0] m_axis_tdata
);
  localparam int NW = RR_W + FRAC_BITS;
  localparam int OW = ((FRAC_BITS + 1 + BLUE_W + 7) / 8) * 8;

  logic en;
  mfs_tag_t term_tag, quo_tag;
  logic [D2_W-1:0] term_d2;
  logic [NW-1:0] term_num, quo;
  logic [FRAC_BITS:0] field_value;
  logic [BLUE_W-1:0] blue_level;

  assign en = !m_axis_tvalid || m_axis_tready;

  mfs_issue #(.BALLS(BALLS), .FRAC_BITS(FRAC_BITS)) u_issue (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .req_type    (s_axis_tuser),
    .ball_index  (s_axis_tdata[2:0]),
    .ball_x      (s_axis_tdata[14:3]),
    .ball_y      (s_axis_tdata[26:15]),
    .ball_radius (s_axis_tdata[34:27]),
    .pixel_x     (s_axis_tdata[43:35]),
    .pixel_y     (s_axis_tdata[52:44]),
    .term_tag    (term_tag),
    .term_d2     (term_d2),
    .term_num    (term_num)
  );

  mfs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_tag  (term_tag),
    .in_d2   (term_d2),
    .in_num  (term_num),
    .out_tag (quo_tag),
    .out_quo (quo)
  );

  mfs_accum #(.BALLS(BALLS), .FRAC_BITS(FRAC_BITS)) u_accum (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .term_tag    (quo_tag),
    .term_quo    (quo),
    .res_valid   (m_axis_tvalid),
    .field_value (field_value),
    .blue_level  (blue_level)
  );

  assign m_axis_tdata = OW'({blue_level, field_value});
endmodule

FILE: src/mfs_issue.sv
// Ball table, per-ball sequencer and squared-distance stages.
`timescale 1ns / 1ps
module mfs_issue
  import mfs_pkg::*;
#(
  parameter int BALLS     = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_type,
  input  logic [IDX_W-1:0]              ball_index,
  input  logic signed [COORD_W-1:0]     ball_x,
  input  logic signed [COORD_W-1:0]     ball_y,
  input  logic [RAD_W-1:0]              ball_radius,
  input  logic [PIX_W-1:0]              pixel_x,
  input  logic [PIX_W-1:0]              pixel_y,
  output mfs_tag_t                      term_tag,
  output logic [D2_W-1:0]               term_d2,
  output logic [RR_W+FRAC_BITS-1:0]     term_num
);
  localparam int CW = (BALLS > 1) ? $clog2(BALLS) : 1;
  localparam logic [CW-1:0] LAST = CW'(BALLS - 1);

  mfs_state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [PIX_W-1:0] px_r, py_r;
  logic accept, issue;

  logic signed [COORD_W-1:0] tab_x [BALLS];
  logic signed [COORD_W-1:0] tab_y [BALLS];
  logic [RAD_W-1:0]          tab_r [BALLS];

  mfs_tag_t tag1, tag2;
  logic signed [DX_W-1:0] dx1, dy1;
  logic [RAD_W-1:0] r1;
  logic signed [SQ_W-1:0] sqx, sqy;
  logic [SQ_W-1:0] sqx2, sqy2;
  logic [RR_W-1:0] rr2;
  logic [D2_W-1:0] sum2;

  assign accept = req_valid && req_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && req_type == REQ_PIXEL) state_next = ST_SCAN;
      ST_SCAN: if (en && cnt == LAST) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: req_ready = en;
      ST_SCAN: issue = en;
      default: req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) cnt <= '0;
      else if (issue) cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_PIXEL) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (accept && req_type == REQ_BALL) begin
      for (int i = 0; i < BALLS; i++) begin
        if ({2'b00, ball_index} == TAB_IDX_W'(i)) begin
          tab_x[i] <= ball_x;
          tab_y[i] <= ball_y;
          tab_r[i] <= ball_radius;
        end
      end
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (rst) tag1 <= '0;
    else if (en) tag1 <= '{vld: issue, first: (cnt == '0), last: (cnt == LAST), hit: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {tab_x[cnt][COORD_W-1], tab_x[cnt]} - {4'b0000, px_r};
      dy1 <= {tab_y[cnt][COORD_W-1], tab_y[cnt]} - {4'b0000, py_r};
      r1  <= tab_r[cnt];
    end
  end

  // stage 2: squares
  assign sqx = dx1 * dx1;
  assign sqy = dy1 * dy1;

  always_ff @(posedge clk) begin
    if (rst) tag2 <= '0;
    else if (en) tag2 <= tag1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= sqx;
      sqy2 <= sqy;
      rr2  <= r1 * r1;
    end
  end

  // stage 3: squared distance and numerator
  assign sum2 = {1'b0, sqx2} + {1'b0, sqy2};

  always_ff @(posedge clk) begin
    if (rst) term_tag <= '0;
    else if (en) term_tag <= '{vld: tag2.vld, first: tag2.first, last: tag2.last,
                              hit: (sum2 == '0)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_d2  <= (sum2 == '0) ? D2_W'(1) : sum2;
      term_num <= {rr2, {FRAC_BITS{1'b0}}};
    end
  end
endmodule

FILE: src/mfs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module mfs_div
  import mfs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  mfs_tag_t                      in_tag,
  input  logic [D2_W-1:0]               in_d2,
  input  logic [RR_W+FRAC_BITS-1:0]     in_num,
  output mfs_tag_t                      out_tag,
  output logic [RR_W+FRAC_BITS-1:0]     out_quo
);
  localparam int NW = RR_W + FRAC_BITS;

  mfs_tag_t         tag_r [NW];
  logic [D2_W-1:0]  rem_r [NW];
  logic [D2_W-1:0]  d_r   [NW];
  logic [NW-1:0]    num_r [NW];
  logic [NW-1:0]    q_r   [NW];

  mfs_tag_t         tag_s [NW];
  logic [D2_W-1:0]  rem_s [NW];
  logic [D2_W-1:0]  d_s   [NW];
  logic [NW-1:0]    num_s [NW];
  logic [NW-1:0]    q_s   [NW];

  logic [D2_W-1:0]  rem_n [NW];
  logic [NW-1:0]    num_n [NW];
  logic [NW-1:0]    q_n   [NW];
  logic [D2_W:0]    trial [NW];

  always_comb begin
    tag_s[0] = in_tag;
    rem_s[0] = '0;
    d_s[0]   = in_d2;
    num_s[0] = in_num;
    q_s[0]   = '0;
    for (int k = 1; k < NW; k++) begin
      tag_s[k] = tag_r[k-1];
      rem_s[k] = rem_r[k-1];
      d_s[k]   = d_r[k-1];
      num_s[k] = num_r[k-1];
      q_s[k]   = q_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      trial[k] = {rem_s[k], num_s[k][NW-1]};
      num_n[k] = {num_s[k][NW-2:0], 1'b0};
      if (trial[k] >= {1'b0, d_s[k]}) begin
        rem_n[k] = D2_W'(trial[k] - {1'b0, d_s[k]});
        q_n[k]   = {q_s[k][NW-2:0], 1'b1};
      end else begin
        rem_n[k] = trial[k][D2_W-1:0];
        q_n[k]   = {q_s[k][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NW; k++) tag_r[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < NW; k++) tag_r[k] <= tag_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        rem_r[k] <= rem_n[k];
        d_r[k]   <= d_s[k];
        num_r[k] <= num_n[k];
        q_r[k]   <= q_n[k];
      end
    end
  end

  assign out_tag = tag_r[NW-1];
  assign out_quo = q_r[NW-1];
endmodule

FILE: src/mfs_accum.sv
// Term accumulation, clamp, blue shading and output register.
`timescale 1ns / 1ps
module mfs_accum
  import mfs_pkg::*;
#(
  parameter int BALLS     = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  mfs_tag_t                      term_tag,
  input  logic [RR_W+FRAC_BITS-1:0]     term_quo,
  output logic                          res_valid,
  output logic [FRAC_BITS:0]            field_value,
  output logic [BLUE_W-1:0]             blue_level
);
  localparam int NW = RR_W + FRAC_BITS;
  localparam int AW = NW + $clog2(BALLS + 1);
  localparam int FW = FRAC_BITS + 1;
  localparam int PW = 2 * FW;
  localparam int BW = PW + BLUE_W;
  localparam logic [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic [AW-1:0] acc, sum_now;
  logic hit_acc, hit_now;
  logic v1, v2;
  logic [FW-1:0] s1, s2;
  logic [PW-1:0] prod2;
  logic [BW-1:0] scaled;
  logic [BW-2*FRAC_BITS-1:0] blue_full;

  assign sum_now = (term_tag.first ? '0 : acc) + (term_tag.hit ? '0 : AW'(term_quo));
  assign hit_now = (term_tag.first ? 1'b0 : hit_acc) | term_tag.hit;

  always_ff @(posedge clk) begin
    if (en && term_tag.vld) begin
      acc     <= sum_now;
      hit_acc <= hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= term_tag.vld && term_tag.last;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= (hit_now || sum_now > ONE) ? '0 : sum_now[FW-1:0];
      s2    <= s1;
      prod2 <= s1 * s1;
    end
  end

  assign scaled    = {prod2, {BLUE_W{1'b0}}} - {{BLUE_W{1'b0}}, prod2};
  assign blue_full = scaled[BW-1:2*FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      field_value <= s2;
      blue_level  <= (blue_full > {{(BW-2*FRAC_BITS-BLUE_W){1'b0}}, BLUE_MAX})
                     ? BLUE_MAX : blue_full[BLUE_W-1:0];
    end
  end
endmodule

FILE: src/mfs_checker.sv
// Port-level assertions for the metaball field shader core, with bind.
`timescale 1ns / 1ps
`include "metaball_field_shader_core_defines.svh"
module mfs_checker
  import mfs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [((FRAC_BITS+1+BLUE_W+7)/8)*8-1:0] m_axis_tdata
);
  localparam int FW = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  logic [FW-1:0] fv;
  logic [BLUE_W-1:0] bl;
  assign fv = m_axis_tdata[FW-1:0];
  assign bl = m_axis_tdata[FW+BLUE_W-1:FW];

  `MFS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
  `MFS_ASSERT_NOW(a_field_max, m_axis_tvalid, fv <= ONE, "field above one")
  `MFS_ASSERT_NOW(a_blue_zero, m_axis_tvalid && fv == '0, bl == '0, "blue set on zero field")
  `MFS_ASSERT_NXT(a_pixel_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_PIXEL, !s_axis_tready, "request taken during pixel scan")
endmodule

bind metaball_field_shader_core mfs_checker #(.FRAC_BITS(FRAC_BITS)) u_mfs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
